### src/rsx_pkg.sv
// Shared types and constants for the RISC subset execute unit.
package rsx_pkg;

    // Default depth of the data store in words
    localparam int DATA_DEPTH_DEF = 1024;

    // Instruction codes; codes above OP_SW are no-ops
    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_ADDI = 4'd1,
        OP_SUB  = 4'd2,
        OP_MUL  = 4'd3,
        OP_J    = 4'd4,
        OP_BEQ  = 4'd5,
        OP_BNE  = 4'd6,
        OP_SLT  = 4'd7,
        OP_LW   = 4'd8,
        OP_SW   = 4'd9
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_OVF    = 2'd1,
        ST_UNINIT = 2'd2,
        ST_MEMOVF = 2'd3
    } t_status;

    // One decoded instruction
    typedef struct packed {
        logic [3:0]         req_type;
        logic [4:0]         dest_reg;
        logic [4:0]         src_a;
        logic [4:0]         src_b;
        logic signed [31:0] immediate;
        logic [15:0]        target_line;
        logic [17:0]        mem_addr;
        logic [15:0]        line_index;
    } t_req;

    // One execution result
    typedef struct packed {
        logic [15:0]        next_line;
        t_status            status;
        logic               reg_written;
        logic [4:0]         written_reg;
        logic signed [31:0] written_value;
        logic [31:0]        executed_count;
    } t_rsp;

endpackage

### src/rsx_req_if.sv
// Valid/ready channel carrying decoded instructions.
interface rsx_req_if;
    logic          valid;
    logic          ready;
    rsx_pkg::t_req req;

    modport source (output valid, output req, input ready);
    modport sink   (input valid, input req, output ready);
endinterface

### src/rsx_rsp_if.sv
// Valid/ready channel carrying execution results.
interface rsx_rsp_if;
    logic          valid;
    logic          ready;
    rsx_pkg::t_rsp rsp;

    modport source (output valid, output rsp, input ready);
    modport sink   (input valid, input rsp, output ready);
endinterface

### src/risc_subset_execute_unit_top.sv
// Execute unit: register file and data store in synchronous memories, two-stage pipeline.
// A transferred instruction passes the execute stage register, then the output register, before its result is valid.
// Throughput: one instruction per cycle while the result side is ready and no clearing sweep runs; register
//   file and data store reads are issued at transfer, writeback happens as the instruction leaves execute.
// Reset: registers read as zero (per-entry init bits), count cleared; the data valid marks
//   are cleared by a sweep over all DATA_DEPTH entries during which no instruction is taken.
module risc_subset_execute_unit_top #(
    parameter int DATA_DEPTH = rsx_pkg::DATA_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rsx_req_if.sink       i_req,
    rsx_rsp_if.source     o_rsp
);

    localparam int          AddrW = $clog2(DATA_DEPTH);
    localparam logic [18:0] DepthC = 19'(DATA_DEPTH);
    localparam logic [AddrW-1:0] LastAddr = AddrW'(DATA_DEPTH - 1);

    // Memories
    logic [31:0] r_rf_mem [32];
    logic [31:0] r_dm_mem [DATA_DEPTH];
    logic        r_vm_mem [DATA_DEPTH];
    logic [31:0] r_rf_init;

    // Clearing sweep of the valid marks
    logic             r_clr_busy;
    logic [AddrW-1:0] r_clr_addr;

    // Execute stage
    logic          r_s1_valid;
    rsx_pkg::t_req r_s1;
    logic [31:0]   r_rd_a;
    logic [31:0]   r_rd_b;
    logic [31:0]   r_rd_dm;
    logic          r_rd_vm;
    logic          r_a_fwd;
    logic          r_b_fwd;
    logic [31:0]   r_fwd_val;
    logic          r_m_fwd;
    logic [31:0]   r_m_fwd_val;
    logic [31:0]   r_count;

    // Output register
    logic          r_out_valid;
    rsx_pkg::t_rsp r_out;

    logic          accept;
    logic          s1_fire;
    logic [31:0]   va;
    logic [31:0]   vb;
    logic [31:0]   sum;
    logic [31:0]   diff;
    logic [31:0]   prod;
    logic          in_range;
    logic          s1_wr;
    logic          s1_sw;
    logic          s1_counts;
    logic [31:0]   n_count;
    logic [15:0]   seq_line;
    logic [15:0]   jmp_line;
    logic [AddrW-1:0] s1_idx;
    logic [AddrW-1:0] in_idx;
    rsx_pkg::t_rsp n_out;

    // Handshakes
    assign s1_fire     = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_clr_busy && (!r_s1_valid || s1_fire);
    assign accept      = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.rsp   = r_out;

    assign in_idx = i_req.req.mem_addr[AddrW-1:0];
    assign s1_idx = r_s1.mem_addr[AddrW-1:0];

    // Operands with forwarding of the write made at the read edge
    always_comb begin
        va = r_a_fwd ? r_fwd_val : (r_rf_init[r_s1.src_a] ? r_rd_a : 32'd0);
        vb = r_b_fwd ? r_fwd_val : (r_rf_init[r_s1.src_b] ? r_rd_b : 32'd0);
    end

    assign sum      = va + vb;
    assign diff     = va - vb;
    assign prod     = va * vb;
    assign in_range = {1'b0, r_s1.mem_addr} < DepthC;
    assign seq_line = r_s1.line_index + 16'd1;
    assign jmp_line = r_s1.target_line - 16'd1;

    // Execute
    always_comb begin
        n_out                = '0;
        n_out.next_line      = seq_line;
        n_out.status         = rsx_pkg::ST_OK;
        s1_wr                = 1'b0;
        s1_sw                = 1'b0;
        s1_counts            = 1'b1;
        unique case (rsx_pkg::t_op'(r_s1.req_type))
            rsx_pkg::OP_ADD: begin
                if ((va[31] ^ sum[31]) & (vb[31] ^ sum[31])) begin
                    n_out.status = rsx_pkg::ST_OVF;
                end else begin
                    s1_wr = 1'b1;
                    n_out.written_value = sum;
                end
            end
            rsx_pkg::OP_ADDI: begin
                s1_wr = 1'b1;
                n_out.written_value = va + r_s1.immediate;
            end
            rsx_pkg::OP_SUB: begin
                if ((va[31] ^ vb[31]) & (va[31] ^ diff[31])) begin
                    n_out.status = rsx_pkg::ST_OVF;
                end else begin
                    s1_wr = 1'b1;
                    n_out.written_value = diff;
                end
            end
            rsx_pkg::OP_MUL: begin
                s1_wr = 1'b1;
                n_out.written_value = prod;
            end
            rsx_pkg::OP_J: begin
                n_out.next_line = jmp_line;
            end
            rsx_pkg::OP_BEQ: begin
                if (va == vb) n_out.next_line = jmp_line;
            end
            rsx_pkg::OP_BNE: begin
                if (va != vb) n_out.next_line = jmp_line;
            end
            rsx_pkg::OP_SLT: begin
                s1_wr = 1'b1;
                n_out.written_value = {31'd0, $signed(va) < $signed(vb)};
            end
            rsx_pkg::OP_LW: begin
                if (in_range && (r_m_fwd || r_rd_vm)) begin
                    s1_wr = 1'b1;
                    n_out.written_value = r_m_fwd ? r_m_fwd_val : r_rd_dm;
                end else begin
                    n_out.status = rsx_pkg::ST_UNINIT;
                end
            end
            rsx_pkg::OP_SW: begin
                if (in_range) begin
                    s1_sw = 1'b1;
                end else begin
                    n_out.status = rsx_pkg::ST_MEMOVF;
                end
            end
            default: begin
                s1_counts = 1'b0;
            end
        endcase
        // Any error halts on the current line with no side effects
        if (n_out.status != rsx_pkg::ST_OK) begin
            n_out.next_line = r_s1.line_index;
            s1_counts       = 1'b0;
        end
        n_count              = r_count + {31'd0, s1_counts};
        n_out.reg_written    = s1_wr;
        n_out.written_reg    = s1_wr ? r_s1.dest_reg : 5'd0;
        n_out.executed_count = n_count;
    end

    // Register file memory: two read ports, one write port
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_a <= r_rf_mem[i_req.req.src_a];
            r_rd_b <= r_rf_mem[i_req.req.src_b];
        end
        if (s1_fire && s1_wr) begin
            r_rf_mem[r_s1.dest_reg] <= n_out.written_value;
        end
    end

    // Data store memory
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_dm <= r_dm_mem[in_idx];
        end
        if (s1_fire && s1_sw) begin
            r_dm_mem[s1_idx] <= va;
        end
    end

    // Valid-mark memory, written by the clearing sweep or by stores
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_vm <= r_vm_mem[in_idx];
        end
        if (r_clr_busy) begin
            r_vm_mem[r_clr_addr] <= 1'b0;
        end else if (s1_fire && s1_sw) begin
            r_vm_mem[s1_idx] <= 1'b1;
        end
    end

    // Pipeline payload and forwarding of the write at the read edge
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1        <= i_req.req;
            r_a_fwd     <= s1_fire && s1_wr && (r_s1.dest_reg == i_req.req.src_a);
            r_b_fwd     <= s1_fire && s1_wr && (r_s1.dest_reg == i_req.req.src_b);
            r_fwd_val   <= n_out.written_value;
            r_m_fwd     <= s1_fire && s1_sw && (r_s1.mem_addr == i_req.req.mem_addr);
            r_m_fwd_val <= va;
        end
        if (s1_fire) begin
            r_out <= n_out;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_rf_init   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == LastAddr) r_clr_busy <= 1'b0;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
                if (s1_wr) r_rf_init[r_s1.dest_reg] <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // No instruction is taken while the valid marks are being cleared
    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_req.ready)
        else $error("instruction taken during clearing sweep");

    // An error result reports no register write and halts on its own line
    a_err_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && n_out.status != rsx_pkg::ST_OK) |->
            (!s1_wr && !s1_sw && n_out.next_line == r_s1.line_index))
        else $error("error result with side effects");

    // The count advances by at most one per result
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> (r_count - $past(r_count)) <= 32'd1)
        else $error("count advanced by more than one");

    // Count only moves when a result is produced
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_fire |=> $stable(r_count))
        else $error("count changed without a result");

endmodule

### tb/sv/risc_subset_execute_unit_top_tb.sv
// Self-checking testbench for the RISC subset execute unit top level.
`timescale 1ns / 1ps

module risc_subset_execute_unit_top_tb;

    localparam int          STORE_DEPTH  = rsx_pkg::DATA_DEPTH_DEF;
    localparam logic [3:0]  OP_NONE_LO   = 4'd10;   // first unused instruction code
    localparam logic [3:0]  OP_NONE_HI   = 4'd15;   // last unused instruction code
    localparam int          DRAIN_LIMIT  = 5000;
    localparam int          LONG_HOLD    = 300;

    logic i_clk;
    logic i_rst_n;

    rsx_req_if req_ch ();
    rsx_rsp_if rsp_ch ();

    risc_subset_execute_unit_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Architectural state mirrored by the predictor
    logic [31:0] arch_regs [32];
    logic [31:0] store_data [STORE_DEPTH];
    bit          store_written [STORE_DEPTH];
    logic [31:0] retired_count;

    rsx_pkg::t_rsp pending_results [$];
    int   mismatch_count;
    int   results_seen;

    // Pacing controls shared with the driver processes
    bit tx_idle_en;
    bit rsp_idle_en;
    int long_hold_cycles;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("risc_subset_execute_unit_top test failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d: %s got %0h expected %0h",
                                      results_seen, name, got, want));
        end
    endtask

    // Executes one instruction on the mirrored state and returns the expected result
    function automatic rsx_pkg::t_rsp execute_instr(input rsx_pkg::t_req r);
        rsx_pkg::t_rsp    res;
        logic [31:0]      va, vb, sum, wval;
        logic [15:0]      nxt;
        rsx_pkg::t_status st;
        logic             wr, counts;
        va     = arch_regs[r.src_a];
        vb     = arch_regs[r.src_b];
        nxt    = r.line_index + 16'd1;
        st     = rsx_pkg::ST_OK;
        wr     = 1'b0;
        wval   = '0;
        counts = 1'b1;
        case (r.req_type)
            rsx_pkg::OP_ADD: begin
                sum = va + vb;
                if (va[31] == vb[31] && sum[31] != va[31]) begin
                    st = rsx_pkg::ST_OVF;
                end else begin
                    wr   = 1'b1;
                    wval = sum;
                end
            end
            rsx_pkg::OP_ADDI: begin
                wr   = 1'b1;
                wval = va + r.immediate;
            end
            rsx_pkg::OP_SUB: begin
                sum = va - vb;
                if (va[31] != vb[31] && sum[31] != va[31]) begin
                    st = rsx_pkg::ST_OVF;
                end else begin
                    wr   = 1'b1;
                    wval = sum;
                end
            end
            rsx_pkg::OP_MUL: begin
                wr   = 1'b1;
                wval = va * vb;
            end
            rsx_pkg::OP_J: begin
                nxt = r.target_line - 16'd1;
            end
            rsx_pkg::OP_BEQ: begin
                if (va == vb) nxt = r.target_line - 16'd1;
            end
            rsx_pkg::OP_BNE: begin
                if (va != vb) nxt = r.target_line - 16'd1;
            end
            rsx_pkg::OP_SLT: begin
                wr   = 1'b1;
                wval = ($signed(va) < $signed(vb)) ? 32'd1 : 32'd0;
            end
            rsx_pkg::OP_LW: begin
                if (r.mem_addr < STORE_DEPTH && store_written[r.mem_addr]) begin
                    wr   = 1'b1;
                    wval = store_data[r.mem_addr];
                end else begin
                    st = rsx_pkg::ST_UNINIT;
                end
            end
            rsx_pkg::OP_SW: begin
                if (r.mem_addr < STORE_DEPTH) begin
                    store_data[r.mem_addr]    = va;
                    store_written[r.mem_addr] = 1'b1;
                end else begin
                    st = rsx_pkg::ST_MEMOVF;
                end
            end
            default: begin
                counts = 1'b0;
            end
        endcase
        // Any error halts on the current line with no state change
        if (st != rsx_pkg::ST_OK) begin
            nxt    = r.line_index;
            wr     = 1'b0;
            wval   = '0;
            counts = 1'b0;
        end
        if (wr) arch_regs[r.dest_reg] = wval;
        if (counts) retired_count = retired_count + 32'd1;
        res.next_line      = nxt;
        res.status         = st;
        res.reg_written    = wr;
        res.written_reg    = wr ? r.dest_reg : 5'd0;
        res.written_value  = wval;
        res.executed_count = retired_count;
        return res;
    endfunction

    // Observe both channels at the rising edge; inputs are predicted before outputs are checked
    initial begin
        rsx_pkg::t_rsp want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1) begin
                if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
                    pending_results.insert(pending_results.size(),
                                           execute_instr(req_ch.req));
                end
                if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
                    results_seen++;
                    if (pending_results.size() == 0) begin
                        report_mismatch($sformatf("result %0d: no instruction pending",
                                                  results_seen));
                    end else begin
                        want = pending_results.pop_front();
                        check_field("next_line", 32'(rsp_ch.rsp.next_line),
                                    32'(want.next_line));
                        check_field("status", 32'(rsp_ch.rsp.status), 32'(want.status));
                        check_field("reg_written", 32'(rsp_ch.rsp.reg_written),
                                    32'(want.reg_written));
                        check_field("written_reg", 32'(rsp_ch.rsp.written_reg),
                                    32'(want.written_reg));
                        check_field("written_value", rsp_ch.rsp.written_value,
                                    want.written_value);
                        check_field("executed_count", rsp_ch.rsp.executed_count,
                                    want.executed_count);
                    end
                end
            end
        end
    end

    // Result-side ready: random stall bursts, plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_cycles > 0) begin
                rsp_ch.ready = 1'b0;
                long_hold_cycles--;
            end else if (stall_left > 0) begin
                rsp_ch.ready = 1'b0;
                stall_left--;
            end else if (rsp_idle_en && $urandom_range(0, 7) == 0) begin
                rsp_ch.ready = 1'b0;
                stall_left   = $urandom_range(1, 17) - 1;
            end else begin
                rsp_ch.ready = 1'b1;
            end
        end
    end

    // Offer one instruction, possibly after an idle burst, and wait for its transfer
    task automatic send_instr(input rsx_pkg::t_req r);
        int gap;
        @(negedge i_clk);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap          = $urandom_range(1, 17);
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.req   = r;
        req_ch.valid = 1'b1;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
    endtask

    // Wait until every issued instruction has produced its result, or until the limit runs out
    task automatic wait_drained(input int limit);
        int n;
        n = 0;
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (pending_results.size() != 0 && n < limit) begin
            @(negedge i_clk);
            n++;
        end
    endtask

    function automatic rsx_pkg::t_req mk(input logic [3:0] op, input logic [4:0] rd,
                                         input logic [4:0] ra, input logic [4:0] rb,
                                         input logic [31:0] imm, input logic [17:0] addr,
                                         input logic [15:0] tgt, input logic [15:0] line);
        rsx_pkg::t_req r;
        r.req_type    = op;
        r.dest_reg    = rd;
        r.src_a       = ra;
        r.src_b       = rb;
        r.immediate   = imm;
        r.target_line = tgt;
        r.mem_addr    = addr;
        r.line_index  = line;
        return r;
    endfunction

    // Small register subset most of the time so results feed later instructions
    function automatic logic [4:0] pick_reg();
        return 5'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 31));
    endfunction

    function automatic logic [31:0] pick_imm();
        case ($urandom_range(0, 7))
            2:       return $urandom_range(0, 15);
            3:       return 32'd0 - $urandom_range(1, 16);
            4:       return 32'h7fff_ffff;
            5:       return 32'h8000_0000;
            6:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Mostly a small window so loads hit stored words; sometimes the top, anywhere, or far out of range
    function automatic logic [17:0] pick_addr();
        case ($urandom_range(0, 9))
            7:       return 18'($urandom_range(STORE_DEPTH - 16, STORE_DEPTH - 1));
            8:       return 18'($urandom_range(0, STORE_DEPTH - 1));
            9:       return 18'($urandom);
            default: return 18'($urandom_range(0, 31));
        endcase
    endfunction

    function automatic rsx_pkg::t_req gen_instr();
        rsx_pkg::t_req r;
        int   pick;
        r.dest_reg    = pick_reg();
        r.src_a       = pick_reg();
        r.src_b       = pick_reg();
        r.immediate   = pick_imm();
        r.target_line = 16'($urandom);
        r.mem_addr    = pick_addr();
        r.line_index  = 16'($urandom);
        pick          = $urandom_range(0, 99);
        if (pick < 18)      r.req_type = rsx_pkg::OP_ADDI;
        else if (pick < 28) r.req_type = rsx_pkg::OP_ADD;
        else if (pick < 38) r.req_type = rsx_pkg::OP_SUB;
        else if (pick < 45) r.req_type = rsx_pkg::OP_MUL;
        else if (pick < 49) r.req_type = rsx_pkg::OP_J;
        else if (pick < 55) r.req_type = rsx_pkg::OP_BEQ;
        else if (pick < 61) r.req_type = rsx_pkg::OP_BNE;
        else if (pick < 68) r.req_type = rsx_pkg::OP_SLT;
        else if (pick < 82) r.req_type = rsx_pkg::OP_LW;
        else if (pick < 94) r.req_type = rsx_pkg::OP_SW;
        else begin
            // noise: any code, any address
            r.req_type = 4'($urandom_range(0, 15));
            r.mem_addr = 18'($urandom);
            r.dest_reg = 5'($urandom_range(0, 31));
        end
        // equal operands half the time so branches go both ways
        if ((r.req_type == rsx_pkg::OP_BEQ || r.req_type == rsx_pkg::OP_BNE) &&
            $urandom_range(0, 1) == 1) begin
            r.src_b = r.src_a;
        end
        return r;
    endfunction

    // Field extremes, every instruction and each error path
    task automatic test_directed_cases();
        send_instr(mk(rsx_pkg::OP_LW,   5'd1,  5'd0, 5'd0, 32'd0, 18'd5, 16'd1, 16'd100));
        send_instr(mk(rsx_pkg::OP_ADDI, 5'd1,  5'd0, 5'd0, 32'h7fff_ffff, 18'd0, 16'd1, 16'd0));
        send_instr(mk(rsx_pkg::OP_ADDI, 5'd2,  5'd0, 5'd0, 32'd1, 18'd0, 16'd1, 16'd1));
        send_instr(mk(rsx_pkg::OP_ADD,  5'd3,  5'd1, 5'd2, 32'd0, 18'd0, 16'd1, 16'd2));
        send_instr(mk(rsx_pkg::OP_ADDI, 5'd4,  5'd0, 5'd0, 32'h8000_0000, 18'd0, 16'd1, 16'd3));
        send_instr(mk(rsx_pkg::OP_SUB,  5'd5,  5'd4, 5'd2, 32'd0, 18'd0, 16'd1, 16'd4));
        send_instr(mk(rsx_pkg::OP_SUB,  5'd5,  5'd2, 5'd4, 32'd0, 18'd0, 16'd1, 16'd5));
        send_instr(mk(rsx_pkg::OP_ADD,  5'd6,  5'd1, 5'd4, 32'd0, 18'd0, 16'd1, 16'd6));
        send_instr(mk(rsx_pkg::OP_MUL,  5'd8,  5'd1, 5'd1, 32'd0, 18'd0, 16'd1, 16'd7));
        send_instr(mk(rsx_pkg::OP_MUL,  5'd9,  5'd4, 5'd6, 32'd0, 18'd0, 16'd1, 16'd8));
        send_instr(mk(rsx_pkg::OP_SLT,  5'd10, 5'd4, 5'd1, 32'd0, 18'd0, 16'd1, 16'd9));
        send_instr(mk(rsx_pkg::OP_SLT,  5'd11, 5'd1, 5'd4, 32'd0, 18'd0, 16'd1, 16'd10));
        send_instr(mk(rsx_pkg::OP_ADDI, 5'd12, 5'd1, 5'd0, 32'd1, 18'd0, 16'd1, 16'd11));
        // jump to line zero wraps to the top index
        send_instr(mk(rsx_pkg::OP_J,    5'd0,  5'd0, 5'd0, 32'd0, 18'd0, 16'd0, 16'd12));
        send_instr(mk(rsx_pkg::OP_J,    5'd0,  5'd0, 5'd0, 32'd0, 18'd0, 16'hffff, 16'd13));
        send_instr(mk(rsx_pkg::OP_BEQ,  5'd0,  5'd1, 5'd1, 32'd0, 18'd0, 16'd200, 16'd14));
        send_instr(mk(rsx_pkg::OP_BEQ,  5'd0,  5'd1, 5'd2, 32'd0, 18'd0, 16'd200, 16'd15));
        send_instr(mk(rsx_pkg::OP_BNE,  5'd0,  5'd1, 5'd2, 32'd0, 18'd0, 16'd300, 16'd16));
        send_instr(mk(rsx_pkg::OP_BNE,  5'd0,  5'd2, 5'd2, 32'd0, 18'd0, 16'd300, 16'd17));
        // store, load back, overwrite, load back at the top word
        send_instr(mk(rsx_pkg::OP_SW,   5'd0,  5'd1, 5'd0, 32'd0, 18'(STORE_DEPTH - 1),
                      16'd1, 16'd18));
        send_instr(mk(rsx_pkg::OP_LW,   5'd13, 5'd0, 5'd0, 32'd0, 18'(STORE_DEPTH - 1),
                      16'd1, 16'd19));
        send_instr(mk(rsx_pkg::OP_SW,   5'd0,  5'd4, 5'd0, 32'd0, 18'(STORE_DEPTH - 1),
                      16'd1, 16'd20));
        send_instr(mk(rsx_pkg::OP_LW,   5'd31, 5'd0, 5'd0, 32'd0, 18'(STORE_DEPTH - 1),
                      16'd1, 16'hffff));
        // out-of-range store and load
        send_instr(mk(rsx_pkg::OP_SW,   5'd0,  5'd1, 5'd0, 32'd0, 18'(STORE_DEPTH),
                      16'd1, 16'd22));
        send_instr(mk(rsx_pkg::OP_SW,   5'd0,  5'd1, 5'd0, 32'd0, 18'h3ffff, 16'd1, 16'd23));
        send_instr(mk(rsx_pkg::OP_LW,   5'd14, 5'd0, 5'd0, 32'd0, 18'h3ffff, 16'd1, 16'd24));
        send_instr(mk(OP_NONE_HI, 5'd15, 5'd1, 5'd2, 32'd1, 18'd3, 16'd1, 16'd25));
        send_instr(mk(OP_NONE_LO, 5'd16, 5'd1, 5'd2, 32'd1, 18'd3, 16'd1, 16'd26));
    endtask

    // Random program with pacing changing every hundred instructions
    task automatic test_random_program(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                tx_idle_en  = ($urandom_range(0, 3) != 0);
                rsp_idle_en = ($urandom_range(0, 3) != 0);
            end
            send_instr(gen_instr());
        end
    endtask

    // Results held off for a long stretch while instructions keep coming
    task automatic test_output_backpressure();
        tx_idle_en       = 1'b0;
        long_hold_cycles = LONG_HOLD;
        repeat (60) send_instr(gen_instr());
    endtask

    // Sender pauses until every pending result is back, then resumes
    task automatic test_drain_pause();
        tx_idle_en  = 1'b1;
        rsp_idle_en = 1'b1;
        repeat (20) send_instr(gen_instr());
        wait_drained(DRAIN_LIMIT);
        repeat (20) send_instr(gen_instr());
    endtask

    // Back-to-back transfers with both sides always ready
    task automatic test_streaming_no_gaps();
        tx_idle_en  = 1'b0;
        rsp_idle_en = 1'b0;
        repeat (380) send_instr(gen_instr());
    endtask

    initial begin
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req       = '0;
        rsp_ch.ready     = 1'b0;
        tx_idle_en       = 1'b1;
        rsp_idle_en      = 1'b1;
        long_hold_cycles = 0;
        mismatch_count   = 0;
        results_seen     = 0;
        retired_count    = '0;
        foreach (arch_regs[i]) arch_regs[i] = '0;
        foreach (store_data[i]) begin
            store_data[i]    = '0;
            store_written[i] = 1'b0;
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_random_program(950);
        test_output_backpressure();
        test_drain_pause();
        test_streaming_no_gaps();

        @(negedge i_clk);
        req_ch.valid = 1'b0;
        wait_drained(DRAIN_LIMIT);
        repeat (8) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_results.size()));
        end
        if (mismatch_count == 0) begin
            $display("risc_subset_execute_unit_top test passed");
        end else begin
            $display("risc_subset_execute_unit_top test failed");
        end
        $finish;
    end

endmodule
